/* rtl/cell_bbox_check_trilinear_stencil_core_macros.svh */
// Assertion macros shared by the mesh-block locate core.
// Included by the modules that carry concurrent checks; depends on nothing.
`ifndef CELL_BBOX_CHECK_TRILINEAR_STENCIL_CORE_MACROS_SVH
`define CELL_BBOX_CHECK_TRILINEAR_STENCIL_CORE_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define CBTSC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled during reset.
`define CBTSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CBTSC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define CBTSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* rtl/cbtsc_pkg.sv */
// Shared types and constants of the mesh-block locate core.
// Used by the channel interfaces, the axis datapath and the top level.
`timescale 1ns / 1ps
package cbtsc_pkg;

  // Table depth default and field widths.
  localparam int unsigned TABLE_DEPTH_DEF = 1024;
  localparam int POS_W       = 32;
  localparam int CW_W        = 31;
  localparam int IDX_W       = 10;
  localparam int HALO_W      = 4;
  localparam int CPS_W       = 7;
  localparam int BIU_W       = 11;
  localparam int BASE_W      = 8;
  localparam int FRAC_W      = 16;

  // Index compare width, wide enough to hold the largest table depth.
  localparam int DEPTH_CMP_W = 17;

  // Datapath widths: offset, edge and halo lengths, compare and product.
  localparam int D_W         = POS_W + 1;
  localparam int EDGE_W      = CPS_W + CW_W;
  localparam int HALO_PROD_W = HALO_W + CW_W;
  localparam int CMP_W       = EDGE_W + 2;
  localparam int PROD_W      = D_W + CW_W + 1;

  // Configuration port.
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  typedef enum logic {
    REG_CELLS_PER_SIDE = 1'b0,
    REG_BLOCKS_IN_USE  = 1'b1
  } cfg_reg_t;

  localparam logic [CPS_W-1:0] CPS_RESET = 7'd16;
  localparam logic [BIU_W-1:0] BIU_RESET = 11'd0;

  // Input item modes.
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // One geometry table entry.
  typedef struct packed {
    logic signed [POS_W-1:0] lo_x;
    logic signed [POS_W-1:0] lo_y;
    logic signed [POS_W-1:0] lo_z;
    logic [CW_W-1:0]         dx;
    logic [CW_W-1:0]         inv;
  } geom_t;

  // Stage load enables handed to the axis datapaths.
  typedef struct packed {
    logic s2;
    logic s3;
  } pipe_en_t;

endpackage

/* rtl/cbtsc_if.sv */
// Valid/ready channel interfaces for query and load beats and for result beats.
// Depends on cbtsc_pkg for the field widths.
`timescale 1ns / 1ps
interface cbtsc_in_if import cbtsc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic [IDX_W-1:0]         block_index;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_y;
  logic signed [POS_W-1:0]  pos_z;
  logic [CW_W-1:0]          cell_width;
  logic [CW_W-1:0]          cell_width_inverse;
  logic [HALO_W-1:0]        halo_cells;

  modport source (output valid, mode, block_index, pos_x, pos_y, pos_z,
                  cell_width, cell_width_inverse, halo_cells, input ready);
  modport sink   (input valid, mode, block_index, pos_x, pos_y, pos_z,
                  cell_width, cell_width_inverse, halo_cells, output ready);
endinterface

interface cbtsc_out_if import cbtsc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     hit;
  logic signed [BASE_W-1:0] base_i;
  logic signed [BASE_W-1:0] base_j;
  logic signed [BASE_W-1:0] base_k;
  logic [FRAC_W-1:0]        frac_x;
  logic [FRAC_W-1:0]        frac_y;
  logic [FRAC_W-1:0]        frac_z;

  modport source (output valid, hit, base_i, base_j, base_k, frac_x, frac_y, frac_z,
                  input ready);
  modport sink   (input valid, hit, base_i, base_j, base_k, frac_x, frac_y, frac_z,
                  output ready);
endinterface

/* rtl/cbtsc_axis.sv */
// One axis of the locate datapath: offset, box test, scaled offset and stencil split.
// Depends on cbtsc_pkg; stage enables come from the top-level pipeline control.
`timescale 1ns / 1ps
module cbtsc_axis import cbtsc_pkg::*; (
  input  logic                     clk,
  input  pipe_en_t                 en,
  input  logic signed [POS_W-1:0]  pos,
  input  logic signed [POS_W-1:0]  lo,
  input  logic [CW_W-1:0]          inv,
  input  logic [EDGE_W-1:0]        edge_len,
  input  logic [HALO_PROD_W-1:0]   halo_len,
  output logic                     inside_r,
  output logic signed [BASE_W-1:0] base_nxt,
  output logic [FRAC_W-1:0]        frac_nxt
);

  localparam int HI_W = PROD_W - 32;
  localparam logic signed [PROD_W-1:0] HALF    = PROD_W'(64'h8000_0000);
  localparam logic signed [HI_W-1:0]   BASE_HI = HI_W'(127);
  localparam logic signed [HI_W-1:0]   BASE_LO = HI_W'(-128);

  logic signed [D_W-1:0]    d_nxt;
  logic signed [D_W-1:0]    d_r;
  logic [CW_W-1:0]          inv_r;
  logic signed [CMP_W-1:0]  d_ext;
  logic signed [CMP_W-1:0]  lo_lim;
  logic signed [CMP_W-1:0]  hi_lim;
  logic                     inside_nxt;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] val;
  logic signed [HI_W-1:0]   hi;

  // Stage 2: exact offset of the point from the lower corner.
  assign d_nxt = $signed({pos[POS_W-1], pos}) - $signed({lo[POS_W-1], lo});

  always_ff @(posedge clk) begin
    if (en.s2) begin
      d_r   <= d_nxt;
      inv_r <= inv;
    end
  end

  // Stage 3: half-open box test widened by the halo, and the scaled offset.
  always_comb begin
    d_ext  = $signed({{(CMP_W-D_W){d_r[D_W-1]}}, d_r});
    lo_lim = -$signed({{(CMP_W-HALO_PROD_W){1'b0}}, halo_len});
    hi_lim = $signed({{(CMP_W-EDGE_W){1'b0}}, edge_len})
           + $signed({{(CMP_W-HALO_PROD_W){1'b0}}, halo_len});
    inside_nxt = (d_ext >= lo_lim) && (d_ext < hi_lim);
    prod_nxt = $signed({{(PROD_W-D_W){d_r[D_W-1]}}, d_r})
             * $signed({{(PROD_W-CW_W){1'b0}}, inv_r});
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      inside_r <= inside_nxt;
      prod_r   <= prod_nxt;
    end
  end

  // Shift by half a cell, then split into saturated floor and fraction.
  always_comb begin
    val = prod_r - HALF;
    hi  = val[PROD_W-1:32];
    if (hi > BASE_HI) begin
      base_nxt = BASE_HI[BASE_W-1:0];
    end else if (hi < BASE_LO) begin
      base_nxt = BASE_LO[BASE_W-1:0];
    end else begin
      base_nxt = hi[BASE_W-1:0];
    end
    frac_nxt = val[31:16];
  end

endmodule

/* rtl/cell_bbox_check_trilinear_stencil_core.sv */
// Mesh-block locate and trilinear stencil core.
// Channels: in_ch takes beats of two kinds. A load beat (mode 0) writes the
// corner, cell width and reciprocal of one geometry table entry and returns
// nothing. A query beat (mode 1) tests a Q16.16 point against one entry and
// returns one result beat on out_ch: hit, saturated base cell indices and
// Q0.16 trilinear fractions, all zero on a miss.
// A query accepted on in_ch moves through stages 1, 2 and 3 and the output
// register to out_ch. One beat is taken every cycle while in_ch.ready is
// high; the geometry table is a single-port memory, written by a load and
// read by a query in the cycle of acceptance, so items touch it strictly in
// order and a query that follows a load to the same entry sees the new data.
// The pipeline closes bubbles, so in_ch.ready stays high while out_ch stalls
// until all three stages and the output register hold results.
// Reset clears the pipeline and sets cells_per_side to 16 and blocks_in_use
// to 0. The table is not cleared: entries hold nothing defined until loaded.
// Registers on the APB port: cells_per_side at 0x0, blocks_in_use at 0x4.
// Depends on cbtsc_pkg, cbtsc_in_if, cbtsc_out_if and cbtsc_axis.
`timescale 1ns / 1ps
`include "cell_bbox_check_trilinear_stencil_core_macros.svh"
module cell_bbox_check_trilinear_stencil_core import cbtsc_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  cbtsc_in_if.sink          in_ch,
  cbtsc_out_if.source       out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [DEPTH_CMP_W-1:0] DEPTH_LIM = DEPTH_CMP_W'(TABLE_DEPTH);

  // Configuration registers.
  logic [CPS_W-1:0] cells_per_side_r;
  logic [BIU_W-1:0] blocks_in_use_r;
  logic             cfg_wr;
  cfg_reg_t         cfg_sel;

  // Pipeline control.
  logic in_accept;
  logic out_free;
  logic s1_free;
  logic s2_free;
  logic s3_free;
  logic s1_v_r;
  logic s2_v_r;
  logic s3_v_r;
  logic s1_use_r;
  logic s2_use_r;
  logic s3_use_r;
  logic out_valid_r;
  pipe_en_t en;

  // Table access.
  geom_t                  mem [TABLE_DEPTH];
  geom_t                  rd_r;
  logic [DEPTH_CMP_W-1:0] idx_ext;
  logic [AW-1:0]          addr;
  logic                   in_table;
  logic                   in_use;
  logic                   mem_wr;

  // Stage payloads.
  logic signed [POS_W-1:0]  s1_px_r;
  logic signed [POS_W-1:0]  s1_py_r;
  logic signed [POS_W-1:0]  s1_pz_r;
  logic [HALO_W-1:0]        s1_halo_r;
  logic [EDGE_W-1:0]        edge_len_r;
  logic [HALO_PROD_W-1:0]   halo_len_r;
  logic                     in_x;
  logic                     in_y;
  logic                     in_z;
  logic signed [BASE_W-1:0] base_i_nxt;
  logic signed [BASE_W-1:0] base_j_nxt;
  logic signed [BASE_W-1:0] base_k_nxt;
  logic [FRAC_W-1:0]        frac_x_nxt;
  logic [FRAC_W-1:0]        frac_y_nxt;
  logic [FRAC_W-1:0]        frac_z_nxt;
  logic                     hit_nxt;

  // Register file write and read-back.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = cfg_reg_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cells_per_side_r <= CPS_RESET;
      blocks_in_use_r  <= BIU_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_CELLS_PER_SIDE: cells_per_side_r <= pwdata[CPS_W-1:0];
        REG_BLOCKS_IN_USE:  blocks_in_use_r  <= pwdata[BIU_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_CELLS_PER_SIDE: prdata = APB_DW'(cells_per_side_r);
      REG_BLOCKS_IN_USE:  prdata = APB_DW'(blocks_in_use_r);
      default:            prdata = '0;
    endcase
  end

  // Each stage takes new data when it is empty or its successor moves on.
  assign out_free    = !out_valid_r || out_ch.ready;
  assign s3_free     = !s3_v_r || out_free;
  assign s2_free     = !s2_v_r || s3_free;
  assign s1_free     = !s1_v_r || s2_free;
  assign in_ch.ready = s1_free;
  assign in_accept   = in_ch.valid && s1_free;
  assign en.s2       = s2_free;
  assign en.s3       = s3_free;

  // Entry address and in-use test.
  assign idx_ext  = DEPTH_CMP_W'(in_ch.block_index);
  assign addr     = idx_ext[AW-1:0];
  assign in_table = idx_ext < DEPTH_LIM;
  assign in_use   = in_table && ({1'b0, in_ch.block_index} < blocks_in_use_r);
  assign mem_wr   = in_accept && (in_ch.mode == MODE_LOAD) && in_table;

  // Geometry memory: loads write, queries read.
  always_ff @(posedge clk) begin
    if (mem_wr) begin
      mem[addr] <= '{lo_x: in_ch.pos_x, lo_y: in_ch.pos_y, lo_z: in_ch.pos_z,
                     dx: in_ch.cell_width, inv: in_ch.cell_width_inverse};
    end
    if (in_accept && (in_ch.mode == MODE_QUERY)) begin
      rd_r <= mem[addr];
    end
  end

  // Valid bits of the three stages and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_v_r <= in_accept && (in_ch.mode == MODE_QUERY);
      end
      if (s2_free) begin
        s2_v_r <= s1_v_r;
      end
      if (s3_free) begin
        s3_v_r <= s2_v_r;
      end
      if (out_free) begin
        out_valid_r <= s3_v_r;
      end
    end
  end

  // Stage 1 captures the query; stage 2 forms the box edge and halo lengths.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_px_r   <= in_ch.pos_x;
      s1_py_r   <= in_ch.pos_y;
      s1_pz_r   <= in_ch.pos_z;
      s1_halo_r <= in_ch.halo_cells;
      s1_use_r  <= in_use;
    end
    if (s2_free) begin
      edge_len_r <= EDGE_W'(cells_per_side_r) * EDGE_W'(rd_r.dx);
      halo_len_r <= HALO_PROD_W'(s1_halo_r) * HALO_PROD_W'(rd_r.dx);
      s2_use_r   <= s1_use_r;
    end
    if (s3_free) begin
      s3_use_r <= s2_use_r;
    end
  end

  cbtsc_axis u_axis_x (
    .clk      (clk),
    .en       (en),
    .pos      (s1_px_r),
    .lo       (rd_r.lo_x),
    .inv      (rd_r.inv),
    .edge_len (edge_len_r),
    .halo_len (halo_len_r),
    .inside_r (in_x),
    .base_nxt (base_i_nxt),
    .frac_nxt (frac_x_nxt)
  );

  cbtsc_axis u_axis_y (
    .clk      (clk),
    .en       (en),
    .pos      (s1_py_r),
    .lo       (rd_r.lo_y),
    .inv      (rd_r.inv),
    .edge_len (edge_len_r),
    .halo_len (halo_len_r),
    .inside_r (in_y),
    .base_nxt (base_j_nxt),
    .frac_nxt (frac_y_nxt)
  );

  cbtsc_axis u_axis_z (
    .clk      (clk),
    .en       (en),
    .pos      (s1_pz_r),
    .lo       (rd_r.lo_z),
    .inv      (rd_r.inv),
    .edge_len (edge_len_r),
    .halo_len (halo_len_r),
    .inside_r (in_z),
    .base_nxt (base_k_nxt),
    .frac_nxt (frac_z_nxt)
  );

  // Output register: a miss carries zero indices and fractions.
  assign hit_nxt = s3_use_r && in_x && in_y && in_z;

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_ch.hit    <= hit_nxt;
      out_ch.base_i <= hit_nxt ? base_i_nxt : '0;
      out_ch.base_j <= hit_nxt ? base_j_nxt : '0;
      out_ch.base_k <= hit_nxt ? base_k_nxt : '0;
      out_ch.frac_x <= hit_nxt ? frac_x_nxt : '0;
      out_ch.frac_y <= hit_nxt ? frac_y_nxt : '0;
      out_ch.frac_z <= hit_nxt ? frac_z_nxt : '0;
    end
  end

  assign out_ch.valid = out_valid_r;

  // A miss beat never carries stencil data.
  `CBTSC_ASSERT_NOW(a_miss_zero, clk, rst_n, out_valid_r && !out_ch.hit, (out_ch.base_i == 0) && (out_ch.base_j == 0) && (out_ch.base_k == 0) && (out_ch.frac_x == 0) && (out_ch.frac_y == 0) && (out_ch.frac_z == 0), "miss beat carries nonzero stencil fields")
  // Loads occupy no pipeline slot; queries always do.
  `CBTSC_ASSERT_NEXT(a_load_no_slot, clk, rst_n, in_accept && (in_ch.mode == MODE_LOAD), !s1_v_r, "load beat entered the result pipeline")
  `CBTSC_ASSERT_NEXT(a_query_slot, clk, rst_n, in_accept && (in_ch.mode == MODE_QUERY), s1_v_r, "query beat lost at stage 1")
  // A stalled final stage keeps its result.
  `CBTSC_ASSERT_NEXT(a_s3_hold, clk, rst_n, s3_v_r && !s3_free, s3_v_r, "stalled stage 3 result dropped")
  // Input back-pressure only when every slot is full.
  `CBTSC_ASSERT_NOW(a_ready_full, clk, rst_n, !in_ch.ready, s1_v_r && s2_v_r && s3_v_r && out_valid_r, "input stalled with a free pipeline slot")

endmodule
